/* rtl/glsf_pkg.sv */
// Shared types, constants and helper functions for the graph link spring force block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package glsf_pkg;

    // Default node memory depth.
    localparam int NODE_COUNT_DEF = 1024;

    // Field widths of the transaction payloads.
    localparam int IDX_IN_W = 10;
    localparam int VAL_W    = 32;
    localparam int Q_W      = 17;
    localparam int REST_W   = 31;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 31;

    // Q1.16 one and register reset values.
    localparam logic [Q_W-1:0]    Q_ONE     = 17'd65536;
    localparam logic [Q_W-1:0]    ALPHA_RST = 17'd65536;
    localparam logic [REST_W-1:0] REST_RST  = 31'd1966080;

    // Operation codes; the unused code behaves as a read.
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_LINK   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REST  = 1'b1;

    // Multiplier operand selects.
    localparam logic [2:0] MUL_SQ = 3'd0;
    localparam logic [2:0] MUL_P  = 3'd1;
    localparam logic [2:0] MUL_A  = 3'd2;
    localparam logic [2:0] MUL_N  = 3'd3;
    localparam logic [2:0] MUL_TB = 3'd4;
    localparam logic [2:0] MUL_SB = 3'd5;

    // Node memory write data selects.
    localparam logic [1:0] WSEL_ITEM = 2'd0;
    localparam logic [1:0] WSEL_T    = 2'd1;
    localparam logic [1:0] WSEL_S    = 2'd2;

    typedef struct packed {
        logic [1:0]           operation;
        logic [IDX_IN_W-1:0]  node_index;
        logic [IDX_IN_W-1:0]  target_index;
        logic signed [31:0]   pos_x;
        logic signed [31:0]   pos_y;
        logic signed [31:0]   pos_z;
        logic signed [31:0]   vel_x;
        logic signed [31:0]   vel_y;
        logic signed [31:0]   vel_z;
        logic [Q_W-1:0]       link_bias;
        logic [Q_W-1:0]       link_strength;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] out_vel_z;
    } t_out_item;

    // One node memory word; element 0 is x, 1 is y, 2 is z.
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
    } t_node;

    // Controller to datapath commands.
    typedef struct packed {
        logic       cap;
        logic       rd_t;
        logic       ld_t;
        logic       ld_s;
        logic       we;
        logic [1:0] wsel;
        logic       diff;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       acc;
        logic [1:0] comp;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       stretch;
        logic       div_init;
        logic       div_step;
        logic       upd_t;
        logic       upd_s;
        logic       out_ld;
        logic       out_item;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic [1:0] op;
    } t_dp_status;

    // Remainder of a 10-bit index by the memory depth, by restoring subtraction.
    function automatic logic [IDX_IN_W-1:0] reduce_index(input logic [IDX_IN_W-1:0] v,
                                                         input int unsigned n);
        logic [IDX_IN_W-1:0] r;
        r = v;
        for (int k = IDX_IN_W - 1; k >= 0; k--) begin
            if ((n << k) < (1 << IDX_IN_W)) begin
                if (r >= IDX_IN_W'(n << k)) begin
                    r = r - IDX_IN_W'(n << k);
                end
            end
        end
        return r;
    endfunction

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic signed [37:0] v);
        logic [31:0] r;
        if (v > 38'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -38'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Magnitude of a signed 32-bit value as an unsigned 32-bit value.
    function automatic logic [31:0] mag32(input logic [31:0] v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

endpackage

/* rtl/glsf_if.sv */
// Valid/ready channel interfaces for the input and result transactions.
// Depends on glsf_pkg for the payload types.
interface glsf_in_if;
    logic                 valid;
    logic                 ready;
    glsf_pkg::t_in_item   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface glsf_out_if;
    logic                 valid;
    logic                 ready;
    glsf_pkg::t_out_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/glsf_ctrl.sv */
// Sequencing state machine for the graph link spring force block.
// Depends on glsf_pkg for the command and status structs and operation codes.
module glsf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  glsf_pkg::t_dp_status  i_status,
    output glsf_pkg::t_dp_cmd     o_cmd
);

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_DISPATCH  = 5'd1;
    localparam logic [4:0] ST_WRITE     = 5'd2;
    localparam logic [4:0] ST_RD_T      = 5'd3;
    localparam logic [4:0] ST_RD_S      = 5'd4;
    localparam logic [4:0] ST_LD_S      = 5'd5;
    localparam logic [4:0] ST_DIFF      = 5'd6;
    localparam logic [4:0] ST_SQ_MUL    = 5'd7;
    localparam logic [4:0] ST_SQ_ACC    = 5'd8;
    localparam logic [4:0] ST_SQRT_INIT = 5'd9;
    localparam logic [4:0] ST_SQRT      = 5'd10;
    localparam logic [4:0] ST_STRETCH   = 5'd11;
    localparam logic [4:0] ST_P_MUL     = 5'd12;
    localparam logic [4:0] ST_DIV_INIT  = 5'd13;
    localparam logic [4:0] ST_DIV       = 5'd14;
    localparam logic [4:0] ST_A_MUL     = 5'd15;
    localparam logic [4:0] ST_N_MUL     = 5'd16;
    localparam logic [4:0] ST_TB_MUL    = 5'd17;
    localparam logic [4:0] ST_UPD_T     = 5'd18;
    localparam logic [4:0] ST_UPD_S     = 5'd19;
    localparam logic [4:0] ST_WR_T      = 5'd20;
    localparam logic [4:0] ST_WR_S      = 5'd21;
    localparam logic [4:0] ST_OUT       = 5'd22;

    localparam logic [4:0] LAST_ITER = 5'd31;
    localparam logic [1:0] LAST_COMP = 2'd2;

    logic [4:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_comp, n_comp;
    logic       r_out_vld, n_out_vld;
    logic       is_link;

    assign is_link     = (i_status.op == glsf_pkg::OP_LINK);
    assign o_out_valid = r_out_vld;
    assign o_in_ready  = (r_state == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_comp    = r_comp;
        o_cmd     = '0;
        o_cmd.comp = r_comp;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (i_status.op)
                    glsf_pkg::OP_WRITE: n_state = ST_WRITE;
                    glsf_pkg::OP_LINK:  n_state = ST_RD_T;
                    default:            n_state = ST_RD_S;
                endcase
            end
            ST_WRITE: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsel = glsf_pkg::WSEL_ITEM;
                n_state    = ST_OUT;
            end
            ST_RD_T: begin
                o_cmd.rd_t = 1'b1;
                n_state    = ST_RD_S;
            end
            ST_RD_S: begin
                o_cmd.ld_t = is_link;
                n_state    = ST_LD_S;
            end
            ST_LD_S: begin
                o_cmd.ld_s = 1'b1;
                n_state    = is_link ? ST_DIFF : ST_OUT;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_comp     = '0;
                n_state    = ST_SQ_MUL;
            end
            ST_SQ_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = glsf_pkg::MUL_SQ;
                n_state       = ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_comp == LAST_COMP) begin
                    n_state = ST_SQRT_INIT;
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = ST_SQ_MUL;
                end
            end
            ST_SQRT_INIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_cnt           = '0;
                n_state         = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt + 5'd1;
                if (r_cnt == LAST_ITER) begin
                    n_state = ST_STRETCH;
                end
            end
            ST_STRETCH: begin
                o_cmd.stretch = 1'b1;
                n_comp        = '0;
                n_state       = ST_P_MUL;
            end
            ST_P_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = glsf_pkg::MUL_P;
                n_state       = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 5'd1;
                if (r_cnt == LAST_ITER) begin
                    n_state = ST_A_MUL;
                end
            end
            ST_A_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = glsf_pkg::MUL_A;
                n_state       = ST_N_MUL;
            end
            ST_N_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = glsf_pkg::MUL_N;
                n_state       = ST_TB_MUL;
            end
            ST_TB_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = glsf_pkg::MUL_TB;
                n_state       = ST_UPD_T;
            end
            ST_UPD_T: begin
                o_cmd.upd_t   = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = glsf_pkg::MUL_SB;
                n_state       = ST_UPD_S;
            end
            ST_UPD_S: begin
                o_cmd.upd_s = 1'b1;
                if (r_comp == LAST_COMP) begin
                    n_state = ST_WR_T;
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = ST_P_MUL;
                end
            end
            ST_WR_T: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsel = glsf_pkg::WSEL_T;
                n_state    = ST_WR_S;
            end
            ST_WR_S: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsel = glsf_pkg::WSEL_S;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                o_cmd.out_item = (i_status.op == glsf_pkg::OP_WRITE);
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The result register is full from its load until the sink takes it.
    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.out_ld) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_comp    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_comp    <= n_comp;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

/* rtl/glsf_datapath.sv */
// Node memory, configuration registers and arithmetic units of the link force block.
// Depends on glsf_pkg; driven by glsf_ctrl through t_dp_cmd.
module glsf_datapath #(
    parameter int NODE_COUNT = glsf_pkg::NODE_COUNT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  glsf_pkg::t_dp_cmd                  i_cmd,
    input  glsf_pkg::t_in_item                 i_item,
    input  logic                               i_cfg_we,
    input  logic [glsf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [glsf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output glsf_pkg::t_dp_status               o_status,
    output glsf_pkg::t_out_item                o_result
);

    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

    // Node memory: one word holds a node's position and velocity.
    glsf_pkg::t_node r_mem [NODE_COUNT];
    glsf_pkg::t_node r_rdata;
    glsf_pkg::t_node wr_data;
    glsf_pkg::t_node item_node;
    logic [IDX_W-1:0] rd_addr, wr_addr;

    glsf_pkg::t_in_item r_item;
    logic [IDX_W-1:0]   r_sidx, r_tidx;
    logic [glsf_pkg::Q_W-1:0]    r_alpha;
    logic [glsf_pkg::REST_W-1:0] r_rest;
    glsf_pkg::t_node    r_t, r_s;
    glsf_pkg::t_out_item r_out;

    logic [31:0] r_d [3];
    logic [63:0] r_prod, r_sq;
    logic [63:0] r_x, r_root, r_bit;
    logic [31:0] r_len, r_str_mag;
    logic        r_str_neg;
    logic [31:0] r_rem, r_quo;
    logic        r_neg;
    logic [33:0] r_nmag;

    logic signed [33:0] diff_raw [3];
    logic [31:0]        diff_sat [3];
    logic               diff_zero;
    logic [31:0]        mag_d;
    logic [33:0]        mul_a;
    logic [31:0]        mul_b;
    logic [65:0]        mul_p;
    logic               nb_neg;
    logic [glsf_pkg::Q_W-1:0] nb_mag;
    logic [63:0]        sq_trial;
    logic [31:0]        len_c;
    logic [32:0]        div_t;
    logic               div_ge;
    logic signed [37:0] delta38;
    logic signed [37:0] vt38, vs38;
    logic [31:0]        vs_base;
    logic               same_node;

    assign o_status.op = r_item.operation;
    assign o_result    = r_out;
    assign same_node   = (r_sidx == r_tidx);

    // Incoming item as a memory word.
    assign item_node.pos = {r_item.pos_z, r_item.pos_y, r_item.pos_x};
    assign item_node.vel = {r_item.vel_z, r_item.vel_y, r_item.vel_x};

    // Memory port address and data selection.
    always_comb begin
        rd_addr = i_cmd.rd_t ? r_tidx : r_sidx;
        wr_addr = (i_cmd.wsel == glsf_pkg::WSEL_T) ? r_tidx : r_sidx;
        case (i_cmd.wsel)
            glsf_pkg::WSEL_T: wr_data = r_t;
            glsf_pkg::WSEL_S: wr_data = r_s;
            default:          wr_data = item_node;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (i_cmd.we) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= glsf_pkg::ALPHA_RST;
            r_rest  <= glsf_pkg::REST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                glsf_pkg::CFG_ALPHA: r_alpha <= i_cfg_data[glsf_pkg::Q_W-1:0];
                glsf_pkg::CFG_REST:  r_rest  <= i_cfg_data[glsf_pkg::REST_W-1:0];
                default: ;
            endcase
        end
    end

    // Difference vector with saturation and the zero-length nudge along x.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            diff_raw[c] = 34'($signed(r_t.pos[c])) + 34'($signed(r_t.vel[c]))
                        - 34'($signed(r_s.pos[c])) - 34'($signed(r_s.vel[c]));
            diff_sat[c] = glsf_pkg::sat32(38'(diff_raw[c]));
        end
        diff_zero = (diff_sat[0] == '0) && (diff_sat[1] == '0) && (diff_sat[2] == '0);
    end

    // Shared multiplier operand selection.
    always_comb begin
        mag_d  = glsf_pkg::mag32(r_d[i_cmd.comp]);
        nb_neg = (r_item.link_bias > glsf_pkg::Q_ONE);
        nb_mag = nb_neg ? (r_item.link_bias - glsf_pkg::Q_ONE)
                        : (glsf_pkg::Q_ONE - r_item.link_bias);
        case (i_cmd.mul_sel)
            glsf_pkg::MUL_SQ: begin
                mul_a = 34'(mag_d);
                mul_b = mag_d;
            end
            glsf_pkg::MUL_P: begin
                mul_a = 34'(mag_d);
                mul_b = r_str_mag;
            end
            glsf_pkg::MUL_A: begin
                mul_a = 34'(r_quo);
                mul_b = 32'(r_alpha);
            end
            glsf_pkg::MUL_N: begin
                mul_a = r_prod[49:16];
                mul_b = 32'(r_item.link_strength);
            end
            glsf_pkg::MUL_TB: begin
                mul_a = r_prod[49:16];
                mul_b = 32'(r_item.link_bias);
            end
            glsf_pkg::MUL_SB: begin
                mul_a = r_nmag;
                mul_b = 32'(nb_mag);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 66'(mul_a) * 66'(mul_b);
    end

    // Square root step, stretch, and divider step.
    always_comb begin
        sq_trial = r_root + r_bit;
        len_c    = r_root[31:0];
        div_t    = {r_rem, r_quo[31]};
        div_ge   = (div_t >= {1'b0, r_len});
    end

    // Velocity updates; on a self link the source builds on the new target velocity.
    always_comb begin
        delta38 = $signed({3'b000, r_prod[50:16]});
        vt38    = 38'($signed(r_t.vel[i_cmd.comp]));
        vs_base = same_node ? r_t.vel[i_cmd.comp] : r_s.vel[i_cmd.comp];
        vs38    = 38'($signed(vs_base));
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_item <= i_item;
            r_sidx <= IDX_W'(glsf_pkg::reduce_index(i_item.node_index, NODE_COUNT));
            r_tidx <= IDX_W'(glsf_pkg::reduce_index(i_item.target_index, NODE_COUNT));
        end
        if (i_cmd.ld_t) begin
            r_t <= r_rdata;
        end
        if (i_cmd.ld_s) begin
            r_s <= r_rdata;
        end
        if (i_cmd.diff) begin
            r_d[0] <= diff_zero ? 32'd1 : diff_sat[0];
            r_d[1] <= diff_sat[1];
            r_d[2] <= diff_sat[2];
            r_sq   <= '0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p[63:0];
        end
        if (i_cmd.mul_en && (i_cmd.mul_sel == glsf_pkg::MUL_TB)) begin
            r_nmag <= r_prod[49:16];
        end
        if (i_cmd.acc) begin
            r_sq <= r_sq + r_prod;
        end
        // Integer square root, two radicand bits per step.
        if (i_cmd.sqrt_init) begin
            r_x    <= r_sq;
            r_root <= '0;
            r_bit  <= SQRT_BIT0;
        end
        if (i_cmd.sqrt_step) begin
            if (r_x >= sq_trial) begin
                r_x    <= r_x - sq_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.stretch) begin
            r_len     <= len_c;
            r_str_neg <= (len_c < {1'b0, r_rest});
            r_str_mag <= (len_c < {1'b0, r_rest}) ? ({1'b0, r_rest} - len_c)
                                                  : (len_c - {1'b0, r_rest});
        end
        // Restoring divide of |d| * |stretch| by the length, one quotient bit per step.
        if (i_cmd.div_init) begin
            r_rem <= r_prod[63:32];
            r_quo <= r_prod[31:0];
            r_neg <= r_d[i_cmd.comp][31] ^ r_str_neg;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? 32'(div_t - {1'b0, r_len}) : div_t[31:0];
            r_quo <= {r_quo[30:0], div_ge};
        end
        if (i_cmd.upd_t) begin
            r_t.vel[i_cmd.comp] <= glsf_pkg::sat32(r_neg ? (vt38 + delta38)
                                                         : (vt38 - delta38));
        end
        if (i_cmd.upd_s) begin
            r_s.vel[i_cmd.comp] <= glsf_pkg::sat32((r_neg ^ nb_neg) ? (vs38 - delta38)
                                                                   : (vs38 + delta38));
        end
        // Result register.
        if (i_cmd.out_ld) begin
            if (i_cmd.out_item) begin
                r_out.out_pos_x <= r_item.pos_x;
                r_out.out_pos_y <= r_item.pos_y;
                r_out.out_pos_z <= r_item.pos_z;
                r_out.out_vel_x <= r_item.vel_x;
                r_out.out_vel_y <= r_item.vel_y;
                r_out.out_vel_z <= r_item.vel_z;
            end else begin
                r_out.out_pos_x <= $signed(r_s.pos[0]);
                r_out.out_pos_y <= $signed(r_s.pos[1]);
                r_out.out_pos_z <= $signed(r_s.pos[2]);
                r_out.out_vel_x <= $signed(r_s.vel[0]);
                r_out.out_vel_y <= $signed(r_s.vel[1]);
                r_out.out_vel_z <= $signed(r_s.vel[2]);
            end
        end
    end

endmodule

/* rtl/graph_link_spring_force.sv */
// Graph link spring force: handles node write, node read and link transactions.
// A link runs a 32-step square root and three 32-step divides, one bit per cycle, on one
// shared multiplier. One transaction is processed at a time; the next is taken while the
// previous result waits in the output register. Reset (synchronous, active low) clears the
// controller and sets alpha to 1.0 and rest length to 30.0; node memory is not cleared.
module graph_link_spring_force #(
    parameter int NODE_COUNT = glsf_pkg::NODE_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    glsf_in_if.sink                          i_item,
    glsf_out_if.source                       o_result,
    input  logic                             i_cfg_we,
    input  logic [glsf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [glsf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    glsf_pkg::t_dp_cmd    cmd;
    glsf_pkg::t_dp_status status;

    // Sequencer.
    glsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Memory and arithmetic.
    glsf_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item.payload),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_result    (o_result.payload)
    );

    // Only a write transaction stores the incoming payload into node memory.
    a_item_write_only_on_write_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.we && (cmd.wsel == glsf_pkg::WSEL_ITEM) |-> status.op == glsf_pkg::OP_WRITE)
        else $error("item written to node memory outside a write transaction");

    // A transaction is processed alone: no new input right after acceptance.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> !i_item.ready)
        else $error("input accepted while a transaction is in progress");

    // Loading a result always presents it on the output channel.
    a_result_presented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_ld |=> o_result.valid)
        else $error("loaded result not presented");

    // The arithmetic phases never overlap.
    a_phases_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.diff, cmd.acc, cmd.sqrt_step, cmd.div_step, cmd.upd_t, cmd.upd_s}))
        else $error("overlapping arithmetic phases");

endmodule
